### design/wacm_pkg.sv
// ----------------------------------------------------------------------------
// wacm_pkg
// Shared widths, constants and controller types for the channel mixer.
// ----------------------------------------------------------------------------
package wacm_pkg;

    localparam int SAMPLE_W       = 16;
    localparam int VOL_W          = 8;
    localparam int CHAN_W         = 5;
    localparam int MAX_VOLUME     = 128;
    localparam int HEADROOM_EXTRA = 2;

    // signed sample times zero-extended volume
    localparam int PROD_W = SAMPLE_W + VOL_W + 1;
    localparam int MAG_W  = SAMPLE_W + VOL_W;
    // divisor (channels + 2) * MAX_VOLUME, channels up to 31
    localparam int DEN_W  = 13;
    // the quotient magnitude always fits the sample width
    localparam int QUO_W  = SAMPLE_W;
    localparam int DIV_STEPS = QUO_W;
    localparam int CNT_W  = $clog2(DIV_STEPS);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_ACC
    } t_state;

    typedef struct packed {
        logic load;
        logic mul;
        logic div_step;
        logic acc;
    } t_cmd;

    typedef struct packed {
        logic last;
        logic out_blocked;
    } t_sts;

endpackage

### design/wacm_ctrl.sv
// ----------------------------------------------------------------------------
// wacm_ctrl
// Sequencer for one request: multiply, divide steps, accumulate.
// ----------------------------------------------------------------------------
module wacm_ctrl
    import wacm_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             w_div_done;

    assign w_div_done = (r_cnt == CNT_W'(DIV_STEPS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                n_state = ST_DIV;
                n_cnt   = '0;
            end
            ST_DIV: begin
                n_cnt = r_cnt + CNT_W'(1);
                if (w_div_done) begin
                    n_state = ST_ACC;
                end
            end
            ST_ACC: begin
                // hold while a finished mix still waits downstream
                if (!(i_sts.last && i_sts.out_blocked)) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            ST_IDLE: o_cmd.load     = i_in_valid;
            ST_MUL:  o_cmd.mul      = 1'b1;
            ST_DIV:  o_cmd.div_step = 1'b1;
            ST_ACC:  o_cmd.acc      = !(i_sts.last && i_sts.out_blocked);
            default: o_cmd = '0;
        endcase
    end

    assign o_in_stall = (r_state != ST_IDLE) || !i_rst_n;

endmodule

### design/wacm_dpath.sv
// ----------------------------------------------------------------------------
// wacm_dpath
// Product, radix-2 restoring divider, accumulator and output register.
// ----------------------------------------------------------------------------
module wacm_dpath
    import wacm_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    input  logic        [VOL_W-1:0]    i_volume,
    input  logic        [CHAN_W-1:0]   i_active_channels,
    input  logic                       i_first_channel,
    input  logic                       i_last_channel,
    input  t_cmd                       i_cmd,
    output t_sts                       o_sts,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic signed [SAMPLE_W-1:0] o_mixed_sample
);

    logic signed [SAMPLE_W-1:0] r_sample;
    logic        [VOL_W-1:0]    r_volume;
    logic        [CHAN_W-1:0]   r_chans;
    logic                       r_first;
    logic                       r_last;

    logic        [DEN_W-1:0]    r_den;
    logic        [DEN_W-1:0]    r_rem;
    logic        [QUO_W-1:0]    r_dvd;
    logic                       r_neg;
    logic        [SAMPLE_W-1:0] r_acc;
    logic                       r_out_valid;
    logic        [SAMPLE_W-1:0] r_mixed;

    logic signed [PROD_W-1:0]   w_prod;
    logic        [PROD_W-1:0]   w_abs;
    logic        [MAG_W-1:0]    w_mag;
    logic        [DEN_W-1:0]    w_den;
    logic        [DEN_W:0]      w_trial;
    logic        [DEN_W:0]      w_diff;
    logic                       w_ge;
    logic        [SAMPLE_W-1:0] w_contrib;
    logic        [SAMPLE_W-1:0] w_base;
    logic        [SAMPLE_W-1:0] w_sum;

    assign w_prod = $signed(r_sample) * $signed({1'b0, r_volume});
    assign w_abs  = w_prod[PROD_W-1] ? PROD_W'(-w_prod) : PROD_W'(w_prod);
    assign w_mag  = w_abs[MAG_W-1:0];
    assign w_den  = DEN_W'(({1'b0, r_chans} + (CHAN_W + 1)'(HEADROOM_EXTRA)) * MAX_VOLUME);

    // one quotient bit a cycle, remainder stays below the divisor
    assign w_trial = {r_rem, r_dvd[QUO_W-1]};
    assign w_diff  = w_trial - {1'b0, r_den};
    assign w_ge    = (w_trial >= {1'b0, r_den});

    assign w_contrib = r_neg ? (-r_dvd) : r_dvd;
    assign w_base    = r_first ? '0 : r_acc;
    assign w_sum     = w_base + w_contrib;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_sample <= i_sample;
            r_volume <= i_volume;
            r_chans  <= i_active_channels;
            r_first  <= i_first_channel;
            r_last   <= i_last_channel;
        end
        if (i_cmd.mul) begin
            r_den <= w_den;
            r_neg <= w_prod[PROD_W-1];
            // upper product bits are below the smallest divisor
            r_rem <= DEN_W'(w_mag[MAG_W-1:QUO_W]);
            r_dvd <= w_mag[QUO_W-1:0];
        end else if (i_cmd.div_step) begin
            r_rem <= w_ge ? w_diff[DEN_W-1:0] : w_trial[DEN_W-1:0];
            r_dvd <= {r_dvd[QUO_W-2:0], w_ge};
        end
        if (i_cmd.acc && r_last) begin
            r_mixed <= w_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.acc) begin
                r_acc <= w_sum;
            end
            if (i_cmd.acc && r_last) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.last        = r_last;
    assign o_sts.out_blocked = r_out_valid && i_out_stall;
    assign o_out_valid       = r_out_valid;
    assign o_mixed_sample    = $signed(r_mixed);

endmodule

### design/weighted_audio_channel_mixer.sv
// ----------------------------------------------------------------------------
// weighted_audio_channel_mixer
// Mixes per-channel samples, scaled by volume and headroom, into one sample.
// ----------------------------------------------------------------------------
// Input channel: i_in_valid / o_in_stall carry one channel's sample, volume,
// active channel count and first/last flags. A request is taken when valid
// is high and stall is low.
// Each request is scaled to sample*volume/((channels+2)*128), truncated
// towards zero, and added to a 16-bit wrapping accumulator. A first flag
// clears the accumulator before adding; a last flag sends the sum out.
// Sequence: after a request is accepted the sequencer runs a multiply step,
// the steps of the radix-2 restoring divider (one quotient bit per cycle)
// and an accumulate step; a last-flagged sum is then registered and shows
// on o_out_valid / o_mixed_sample. No new request is taken before then.
// Output channel: the result sits in an output register and holds while
// i_out_stall is high. The next request is already taken and worked on;
// only a second last-flagged result waits in the accumulate cycle.
// Reset (synchronous, active low) clears the accumulator, empties the
// output register and returns the sequencer to idle.
// ----------------------------------------------------------------------------
module weighted_audio_channel_mixer
    import wacm_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    input  logic        [VOL_W-1:0]    i_volume,
    input  logic        [CHAN_W-1:0]   i_active_channels,
    input  logic                       i_first_channel,
    input  logic                       i_last_channel,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic signed [SAMPLE_W-1:0] o_mixed_sample
);

    t_cmd w_cmd;
    t_sts w_sts;

    wacm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    wacm_dpath u_dpath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_sample          (i_sample),
        .i_volume          (i_volume),
        .i_active_channels (i_active_channels),
        .i_first_channel   (i_first_channel),
        .i_last_channel    (i_last_channel),
        .i_cmd             (w_cmd),
        .o_sts             (w_sts),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_mixed_sample    (o_mixed_sample)
    );

endmodule

### design/wacm_checker.sv
// ----------------------------------------------------------------------------
// wacm_checker
// Port-level checks on the mixer's handshakes and sequencing.
// ----------------------------------------------------------------------------
module wacm_checker
    import wacm_pkg::*;
(
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       o_in_stall,
    input logic                       o_out_valid,
    input logic                       i_out_stall,
    input logic signed [SAMPLE_W-1:0] o_mixed_sample
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_mixed_sample))
        else $error("stalled result changed");

    // a taken request keeps the input closed through the multiply state and the first divide step
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall ##1 o_in_stall)
        else $error("request taken while busy");

    // no result can appear straight after a request is taken
    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> !$rose(o_out_valid))
        else $error("result too early");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind weighted_audio_channel_mixer wacm_checker u_wacm_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_mixed_sample (o_mixed_sample)
);
